// ===== sv/sum_checksum_frame_receiver_macros.svh =====
// ---------------------------------------------------------------------------
// sum checksum frame receiver: assertion macros
// concurrent checks on the rising clock edge, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef SUM_CHECKSUM_FRAME_RECEIVER_MACROS_SVH
`define SUM_CHECKSUM_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define SCFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define SCFR_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SCFR_ASSERT(lbl, clk, rst, prop, msg)
`define SCFR_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== sv/scfr_pkg.sv =====
// ---------------------------------------------------------------------------
// sum checksum frame receiver package
// status codes, receiver states, result layout and start bytes
// ---------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

  // result kinds, carried on tuser
  typedef enum logic [1:0] {
    STATUS_PAYLOAD  = 2'd0,
    STATUS_BAD_SUM  = 2'd1,
    STATUS_ZERO_LEN = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_t;

  // receiver phases plus the two replay steps
  typedef enum logic [5:0] {
    S_HUNT = 6'b000001,
    S_SIZE = 6'b000010,
    S_DATA = 6'b000100,
    S_SUM  = 6'b001000,
    S_RD   = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  // tdata fields of one result, first field in the highest bits
  typedef struct packed {
    logic [15:0] bad_frames;
    logic [15:0] good_frames;
    logic [7:0]  sum_computed;
    logic [7:0]  sum_received;
    logic [5:0]  byte_index;
    logic [7:0]  payload_byte;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = 64;

  localparam logic [7:0] START_B = 8'h62;
  localparam logic [7:0] START_A = 8'h61;

endpackage

`default_nettype wire

// ===== sv/scfr_ram.sv =====
// ---------------------------------------------------------------------------
// generic single-port-write ram
// one write port, one read port, read data registered on read enable
// ---------------------------------------------------------------------------
`default_nettype none

module scfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sum_checksum_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// sum checksum frame receiver
// length-prefixed serial frames with an 8-bit additive checksum; good
// frames are replayed byte by byte from a payload ram
// ---------------------------------------------------------------------------
//
// channel  dir  tdata (low bit up)                          tuser   tlast
// s_axis   in   rx_byte                                     -       -
// m_axis   out  payload_byte, byte_index, sum_received,     status  last
//               sum_computed, good_frames, bad_frames, pad
//
// length and checksum bytes wait for the output register to be free, start
// and payload bytes never wait
// a good frame replays each payload byte as a ram read, then the output
// register load once it has room (single read port of the payload ram)
// no input is taken while a replay runs
// reset is synchronous and clears control state and counters only; the
// payload ram is not cleared, a replay reads only entries of its own frame
// ---------------------------------------------------------------------------
`default_nettype none

`include "sum_checksum_frame_receiver_macros.svh"

module sum_checksum_frame_receiver #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input request: one received byte
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // rx_byte
  // output request: one result
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [scfr_pkg::TDATA_W-1:0] m_axis_tdata, // payload_byte, byte_index,
                                                     // sum_received, sum_computed,
                                                     // good_frames, bad_frames
  output logic [1:0]      m_axis_tuser,   // status
  output logic            m_axis_tlast    // last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  scfr_pkg::state_t  state;
  logic [6:0]        frame_length;   // bytes in the current frame
  logic [6:0]        bytes_stored;   // payload bytes written so far
  logic [7:0]        running_sum;    // wrapping sum of start, length, payload
  logic [7:0]        sum_rx;         // checksum byte of the frame
  logic [15:0]       good_count;
  logic [15:0]       bad_count;
  logic [6:0]        rd_idx;         // replay position

  // output register, parts the two sides
  logic              out_valid;
  scfr_pkg::status_t out_status;
  logic              out_last;
  scfr_pkg::result_t out_res;

  logic       in_acc;
  logic       out_free;
  logic       out_load;
  logic       is_start;
  logic       len_bad;
  logic       sum_match;
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;
  logic       replay_last;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~out_valid | m_axis_tready;
  assign is_start = (s_axis_tdata == scfr_pkg::START_B) ||
                    (s_axis_tdata == scfr_pkg::START_A);
  assign len_bad  = (s_axis_tdata == 8'd0) || (s_axis_tdata > MAX_LEN);
  assign sum_match   = (running_sum == s_axis_tdata);
  assign replay_last = ((rd_idx + 7'd1) == frame_length);

  // hunting and payload bytes never raise a result, so they need no room
  always_comb begin
    case (state)
      scfr_pkg::S_HUNT, scfr_pkg::S_DATA: s_axis_tready = 1'b1;
      scfr_pkg::S_SIZE, scfr_pkg::S_SUM:  s_axis_tready = out_free;
      default:                            s_axis_tready = 1'b0;
    endcase
  end

  // a new result enters the output register
  always_comb begin
    case (state)
      scfr_pkg::S_SIZE: out_load = in_acc && len_bad;
      scfr_pkg::S_SUM:  out_load = in_acc && !sum_match;
      scfr_pkg::S_EMIT: out_load = out_free;
      default:          out_load = 1'b0;
    endcase
  end

  // store writes happen while receiving, reads only after the checksum byte,
  // so the same entry is never written and read in one cycle
  assign ram_we = (state == scfr_pkg::S_DATA) && in_acc;
  assign ram_re = (state == scfr_pkg::S_RD);

  scfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bytes_stored[AW-1:0]),
    .wdata (s_axis_tdata),
    .re    (ram_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= scfr_pkg::S_HUNT;
      frame_length <= 7'd0;
      bytes_stored <= 7'd0;
      running_sum  <= 8'd0;
      good_count   <= 16'd0;
      bad_count    <= 16'd0;
      rd_idx       <= 7'd0;
      out_valid    <= 1'b0;
    end else begin
      // result loaded, or taken downstream
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        scfr_pkg::S_HUNT: begin
          if (in_acc && is_start) begin
            running_sum  <= s_axis_tdata;
            bytes_stored <= 7'd0;
            state        <= scfr_pkg::S_SIZE;
          end
        end
        scfr_pkg::S_SIZE: begin
          if (in_acc) begin
            if (len_bad) begin
              // empty or oversized frame: report and drop
              out_status <= (s_axis_tdata == 8'd0) ? scfr_pkg::STATUS_ZERO_LEN
                                                   : scfr_pkg::STATUS_TOO_LONG;
              out_last   <= 1'b1;
              out_res.payload_byte <= 8'd0;
              out_res.byte_index   <= 6'd0;
              out_res.sum_received <= 8'd0;
              out_res.sum_computed <= 8'd0;
              out_res.good_frames  <= good_count;
              out_res.bad_frames   <= bad_count;
              state      <= scfr_pkg::S_HUNT;
            end else begin
              frame_length <= s_axis_tdata[6:0];
              running_sum  <= running_sum + s_axis_tdata;
              state        <= scfr_pkg::S_DATA;
            end
          end
        end
        scfr_pkg::S_DATA: begin
          if (in_acc) begin
            running_sum  <= running_sum + s_axis_tdata;
            bytes_stored <= bytes_stored + 7'd1;
            if ((bytes_stored + 7'd1) >= frame_length) begin
              state <= scfr_pkg::S_SUM;
            end
          end
        end
        scfr_pkg::S_SUM: begin
          if (in_acc) begin
            sum_rx <= s_axis_tdata;
            if (sum_match) begin
              good_count <= good_count + 16'd1;
              rd_idx     <= 7'd0;
              state      <= scfr_pkg::S_RD;
            end else begin
              bad_count  <= bad_count + 16'd1;
              out_status <= scfr_pkg::STATUS_BAD_SUM;
              out_last   <= 1'b1;
              out_res.payload_byte <= 8'd0;
              out_res.byte_index   <= 6'd0;
              out_res.sum_received <= s_axis_tdata;
              out_res.sum_computed <= running_sum;
              out_res.good_frames  <= good_count;
              out_res.bad_frames   <= bad_count + 16'd1;
              state      <= scfr_pkg::S_HUNT;
            end
          end
        end
        scfr_pkg::S_RD: begin
          // ram read issued this cycle, data ready next cycle
          state <= scfr_pkg::S_EMIT;
        end
        scfr_pkg::S_EMIT: begin
          // ram output holds until the output register has room
          if (out_free) begin
            out_status <= scfr_pkg::STATUS_PAYLOAD;
            out_last   <= replay_last;
            out_res.payload_byte <= ram_rdata;
            out_res.byte_index   <= rd_idx[5:0];
            out_res.sum_received <= sum_rx;
            out_res.sum_computed <= running_sum;
            out_res.good_frames  <= good_count;
            out_res.bad_frames   <= bad_count;
            rd_idx     <= rd_idx + 7'd1;
            state      <= replay_last ? scfr_pkg::S_HUNT : scfr_pkg::S_RD;
          end
        end
        default: begin
          state <= scfr_pkg::S_HUNT;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(scfr_pkg::TDATA_W - scfr_pkg::RESULT_W)'(0), out_res};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  // no byte is taken while a good frame is replayed
  `SCFR_ASSERT(a_no_input_in_replay, clk, rst,
    (state == scfr_pkg::S_RD || state == scfr_pkg::S_EMIT) |-> !s_axis_tready,
    "input taken during replay")
  // writes stay inside the announced frame length
  `SCFR_ASSERT(a_write_in_frame, clk, rst,
    ram_we |-> (bytes_stored < frame_length),
    "payload write beyond frame length")
  // replay reads only entries written in this frame
  `SCFR_ASSERT(a_read_in_frame, clk, rst,
    ram_re |-> (rd_idx < frame_length),
    "payload read beyond frame length")
  // a payload read never coincides with a payload write
  `SCFR_ASSERT_NEVER(a_no_rw_overlap, clk, rst,
    ram_we && ram_re,
    "payload ram read and write in one cycle")
  // the last replayed byte is the final byte of the frame
  `SCFR_ASSERT(a_last_at_end, clk, rst,
    (out_valid && out_status == scfr_pkg::STATUS_PAYLOAD && out_last) |->
      ({1'b0, out_res.byte_index} == (frame_length - 7'd1)),
    "last flag not on final payload byte")

endmodule

`default_nettype wire
